>>> hdl/frt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frt_pkg;

	// Field widths of table entries, cell commands and sweep tokens
	localparam int unsigned MAP_W   = 64;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned BYTES_W = 16;
	localparam int unsigned HELD_W  = 18;
	localparam int unsigned POS_W   = 6;
	localparam int unsigned LEN_W   = 10;
	localparam int unsigned IDX_W   = 6;

	// Request opcodes
	localparam logic [1:0] OP_ACCEPT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_TAKE   = 2'd2;

	// Result codes
	localparam logic [2:0] RES_REJECT   = 3'd0;
	localparam logic [2:0] RES_DUP      = 3'd1;
	localparam logic [2:0] RES_NEW      = 3'd2;
	localparam logic [2:0] RES_COMPLETE = 3'd3;
	localparam logic [2:0] RES_FOUND    = 3'd4;
	localparam logic [2:0] RES_NOTFOUND = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_TTL       = 2'd0;
	localparam logic [1:0] CFG_MAX_ENT   = 2'd1;
	localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

	// Commands broadcast to every cell
	localparam logic [3:0] CELL_NOP      = 4'd0;
	localparam logic [3:0] CELL_EXPIRE   = 4'd1;
	localparam logic [3:0] CELL_OLDEST   = 4'd2;
	localparam logic [3:0] CELL_SHIFT    = 4'd3;
	localparam logic [3:0] CELL_LOOKUP   = 4'd4;
	localparam logic [3:0] CELL_INSERT   = 4'd5;
	localparam logic [3:0] CELL_UPDATE   = 4'd6;
	localparam logic [3:0] CELL_KILL_POS = 4'd7;
	localparam logic [3:0] CELL_KILL_TGT = 4'd8;

	typedef struct packed {
		logic               valid;
		logic               tgt;
		logic [31:0]        origin;
		logic [31:0]        msg_id;
		logic [31:0]        dest;
		logic [CNT_W-1:0]   count;
		logic [7:0]         flags;
		logic [MAP_W-1:0]   have;
		logic [31:0]        first;
		logic [BYTES_W-1:0] bytes;
	} frt_entry_t;

	typedef struct packed {
		logic [3:0]         op;
		logic               skip_tgt;
		logic [31:0]        now;
		logic [31:0]        ttl;
		logic [31:0]        origin;
		logic [31:0]        msg_id;
		logic [31:0]        dest;
		logic [CNT_W-1:0]   total;
		logic [7:0]         flags;
		logic [IDX_W-1:0]   idx;
		logic [LEN_W-1:0]   len;
		logic [POS_W-1:0]   pos;
	} frt_cmd_t;

	typedef struct packed {
		logic               active;
		logic               found;
		logic [31:0]        first;
		logic [POS_W-1:0]   pos;
		logic [BYTES_W-1:0] bytes;
		logic [HELD_W-1:0]  acc_bytes;
		logic [CNT_W-1:0]   acc_cnt;
	} frt_tok_t;

	// Bitmap with the low cnt bits set
	function automatic logic [MAP_W-1:0] full_map(input logic [CNT_W-1:0] cnt);
		logic [MAP_W-1:0] m;
		if (cnt >= CNT_W'(MAP_W)) begin
			m = '1;
		end else begin
			m = ~({MAP_W{1'b1}} << cnt);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

>>> hdl/frt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module frt_cell #(
	parameter int unsigned POS = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire frt_pkg::frt_cmd_t cmd,
	input  wire frt_pkg::frt_tok_t tok_in,
	output frt_pkg::frt_tok_t      tok_out,
	input  wire frt_pkg::frt_entry_t above,
	input  wire logic              below_valid,
	output frt_pkg::frt_entry_t    entry
);

	frt_pkg::frt_entry_t entry_q;
	frt_pkg::frt_tok_t   tok_q;
	frt_pkg::frt_tok_t   tok_nxt;
	logic [31:0]         age;
	logic [31:0]         diff;
	logic                expired;
	logic                consider;
	logic                replace;
	logic                key_hit;
	logic                here;

	assign entry   = entry_q;
	assign tok_out = tok_q;
	assign here    = (cmd.pos == frt_pkg::POS_W'(POS));

	// Work out this cell's share of a sweep
	always_comb begin
		age      = cmd.now - entry_q.first;
		diff     = entry_q.first - tok_in.first;
		expired  = entry_q.valid && (age >= cmd.ttl);
		consider = entry_q.valid && !(cmd.skip_tgt && entry_q.tgt);
		replace  = consider && (!tok_in.found || diff[31]);
		key_hit  = entry_q.valid && (entry_q.origin == cmd.origin)
			&& (entry_q.msg_id == cmd.msg_id);
		tok_nxt  = tok_in;
		if (cmd.op == frt_pkg::CELL_EXPIRE && expired) begin
			tok_nxt.acc_bytes = tok_in.acc_bytes + frt_pkg::HELD_W'(entry_q.bytes);
			tok_nxt.acc_cnt   = tok_in.acc_cnt + frt_pkg::CNT_W'(1);
		end
		if (cmd.op == frt_pkg::CELL_OLDEST && replace) begin
			tok_nxt.found = 1'b1;
			tok_nxt.first = entry_q.first;
			tok_nxt.pos   = frt_pkg::POS_W'(POS);
			tok_nxt.bytes = entry_q.bytes;
		end
	end

	// Hand the sweep token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (tok_in.active) begin
			tok_q <= tok_nxt;
		end else begin
			tok_q <= '0;
		end
	end

	// Update the held entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.valid <= 1'b0;
			entry_q.tgt   <= 1'b0;
		end else begin
			case (cmd.op)
				frt_pkg::CELL_EXPIRE: begin
					if (tok_in.active && expired) begin
						entry_q.valid <= 1'b0;
						entry_q.tgt   <= 1'b0;
					end
				end
				frt_pkg::CELL_SHIFT: begin
					if (!entry_q.valid) begin
						entry_q <= above;
					end else if (!below_valid) begin
						entry_q.valid <= 1'b0;
						entry_q.tgt   <= 1'b0;
					end
				end
				frt_pkg::CELL_LOOKUP: begin
					entry_q.tgt <= key_hit;
				end
				frt_pkg::CELL_INSERT: begin
					if (here) begin
						entry_q.valid  <= 1'b1;
						entry_q.tgt    <= 1'b1;
						entry_q.origin <= cmd.origin;
						entry_q.msg_id <= cmd.msg_id;
						entry_q.dest   <= cmd.dest;
						entry_q.count  <= cmd.total;
						entry_q.flags  <= cmd.flags;
						entry_q.have   <= '0;
						entry_q.first  <= cmd.now;
						entry_q.bytes  <= '0;
					end
				end
				frt_pkg::CELL_UPDATE: begin
					if (entry_q.tgt) begin
						entry_q.bytes <= entry_q.bytes + frt_pkg::BYTES_W'(cmd.len);
						entry_q.have  <= entry_q.have
							| (frt_pkg::MAP_W'(1) << cmd.idx);
						entry_q.flags <= entry_q.flags | cmd.flags;
					end
				end
				frt_pkg::CELL_KILL_POS: begin
					if (here) begin
						entry_q.valid <= 1'b0;
						entry_q.tgt   <= 1'b0;
					end
				end
				frt_pkg::CELL_KILL_TGT: begin
					if (entry_q.tgt) begin
						entry_q.valid <= 1'b0;
						entry_q.tgt   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/fragment_reassembly_tracker.sv
// Reassembly tracker for fragmented messages, keyed by origin and message id.
// Entries sit in a row of MAX_ENTRIES cells kept in insertion order; one
// request is handled at a time and the next may be taken while a result still
// waits at the output. A query is a lookup and a read-back of the target
// entry. A take of a complete entry adds its removal and compaction. A
// fragment accept runs an expiry sweep, then compaction, then the lookup,
// plus for each eviction an oldest-entry sweep and compaction. Sweeps and
// compaction are paced by the token that walks the cell row one cell per
// clock and by gaps that move up the row one cell per clock. Fragments that
// fail the request checks go straight to the result.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembly_tracker #(
	parameter int unsigned MAX_ENTRIES   = 16,
	parameter int unsigned MAX_FRAGS     = 64,
	parameter int unsigned MAX_FRAG_DATA = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] origin,
	input  wire logic [31:0] msg_id,
	input  wire logic [31:0] dest,
	input  wire logic [7:0]  frag_index,
	input  wire logic [7:0]  frag_total,
	input  wire logic [9:0]  frag_len,
	input  wire logic [7:0]  frag_flags,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       result_code,
	output logic [6:0]       count_out,
	output logic [63:0]      have_bitmap,
	output logic [31:0]      dest_out,
	output logic [7:0]       flags_out,
	output logic [15:0]      total_len,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EXP_GO = 4'd1;
	localparam logic [3:0] S_EXP_W  = 4'd2;
	localparam logic [3:0] S_CMP    = 4'd3;
	localparam logic [3:0] S_LOOK   = 4'd4;
	localparam logic [3:0] S_RD     = 4'd5;
	localparam logic [3:0] S_DEC    = 4'd6;
	localparam logic [3:0] S_INS    = 4'd7;
	localparam logic [3:0] S_DUP    = 4'd8;
	localparam logic [3:0] S_BUD    = 4'd9;
	localparam logic [3:0] S_OLD_GO = 4'd10;
	localparam logic [3:0] S_OLD_W  = 4'd11;
	localparam logic [3:0] S_KILL   = 4'd12;
	localparam logic [3:0] S_UPD    = 4'd13;
	localparam logic [3:0] S_FIN    = 4'd14;
	localparam logic [3:0] S_KILLT  = 4'd15;

	logic [3:0]   state_q;
	logic [3:0]   ret_q;
	logic [31:0]  ttl_q;
	logic [4:0]   max_ent_q;
	logic [17:0]  max_bytes_q;
	logic [17:0]  held_q;
	logic [CW-1:0] count_q;
	logic         skip_q;

	// Latched request
	logic [1:0]   op_q;
	logic [31:0]  origin_q;
	logic [31:0]  msg_id_q;
	logic [31:0]  dest_q;
	logic [7:0]   idx_q;
	logic [7:0]   total_q;
	logic [9:0]   len_q;
	logic [7:0]   flags_q;
	logic [31:0]  now_q;

	// Entry read back from the target cell
	logic         rd_found_q;
	logic [6:0]   rd_count_q;
	logic [63:0]  rd_have_q;
	logic [31:0]  rd_dest_q;
	logic [7:0]   rd_flags_q;
	logic [15:0]  rd_bytes_q;

	// Oldest-entry pick
	logic [frt_pkg::POS_W-1:0]   best_pos_q;
	logic [frt_pkg::BYTES_W-1:0] best_bytes_q;

	// Pending result and output register
	logic [2:0]   r_code_q;
	logic [6:0]   r_count_q;
	logic [63:0]  r_have_q;
	logic [31:0]  r_dest_q;
	logic [7:0]   r_flags_q;
	logic [15:0]  r_len_q;
	logic         out_valid_q;
	logic [2:0]   o_code_q;
	logic [6:0]   o_count_q;
	logic [63:0]  o_have_q;
	logic [31:0]  o_dest_q;
	logic [7:0]   o_flags_q;
	logic [15:0]  o_len_q;

	frt_pkg::frt_cmd_t   cmd;
	frt_pkg::frt_entry_t ent [MAX_ENTRIES];
	frt_pkg::frt_tok_t   tok [MAX_ENTRIES+1];

	logic         gap;
	logic         c_found;
	logic [6:0]   c_count;
	logic [63:0]  c_have;
	logic [31:0]  c_dest;
	logic [7:0]   c_flags;
	logic [15:0]  c_bytes;
	logic [6:0]   lim;
	logic         bad_frag;
	logic         over;
	logic [63:0]  bit_sel;
	logic         accept_in;
	logic         out_free;
	logic [MAX_ENTRIES-1:0] valid_vec;
	logic [MAX_ENTRIES-1:0] tgt_vec;

	assign in_stall    = (state_q != S_IDLE);
	assign accept_in   = in_valid && !in_stall;
	assign out_free    = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign result_code = o_code_q;
	assign count_out   = o_count_q;
	assign have_bitmap = o_have_q;
	assign dest_out    = o_dest_q;
	assign flags_out   = o_flags_q;
	assign total_len   = o_len_q;

	// Build the cell row
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		frt_pkg::frt_entry_t above_w;
		logic                below_w;
		if (g == MAX_ENTRIES - 1) begin : g_top
			assign above_w = '0;
		end else begin : g_mid
			assign above_w = ent[g+1];
		end
		if (g == 0) begin : g_bot
			assign below_w = 1'b1;
		end else begin : g_up
			assign below_w = ent[g-1].valid;
		end
		assign valid_vec[g] = ent[g].valid;
		assign tgt_vec[g]   = ent[g].tgt;
		frt_cell #(
			.POS(g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.tok_in     (tok[g]),
			.tok_out    (tok[g+1]),
			.above      (above_w),
			.below_valid(below_w),
			.entry      (ent[g])
		);
	end

	// Launch a sweep token into the first cell
	always_comb begin
		tok[0]        = '0;
		tok[0].active = (state_q == S_EXP_GO) || (state_q == S_OLD_GO);
	end

	// Detect gaps and read back the target entry
	always_comb begin
		gap     = 1'b0;
		c_found = 1'b0;
		c_count = '0;
		c_have  = '0;
		c_dest  = '0;
		c_flags = '0;
		c_bytes = '0;
		for (int i = 1; i < MAX_ENTRIES; i++) begin
			gap = gap | (ent[i].valid & ~ent[i-1].valid);
		end
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (ent[i].tgt) begin
				c_found = 1'b1;
				c_count = c_count | ent[i].count;
				c_have  = c_have | ent[i].have;
				c_dest  = c_dest | ent[i].dest;
				c_flags = c_flags | ent[i].flags;
				c_bytes = c_bytes | ent[i].bytes;
			end
		end
	end

	// Checks on the request and the budget
	always_comb begin
		bad_frag = (frag_total == 8'd0)
			|| (9'(frag_total) > 9'(MAX_FRAGS))
			|| (frag_index >= frag_total)
			|| (11'(frag_len) > 11'(MAX_FRAG_DATA))
			|| ((9'(frag_index) + 9'd1 < 9'(frag_total))
				&& (frag_len != 10'(MAX_FRAG_DATA)));
		if (max_ent_q == 5'd0) begin
			lim = 7'd1;
		end else if (7'(max_ent_q) > 7'(MAX_ENTRIES)) begin
			lim = 7'(MAX_ENTRIES);
		end else begin
			lim = 7'(max_ent_q);
		end
		over    = (19'(held_q) + 19'(len_q)) > 19'(max_bytes_q);
		bit_sel = 64'(1) << idx_q[5:0];
	end

	// Drive the cell command
	always_comb begin
		cmd          = '0;
		cmd.op       = frt_pkg::CELL_NOP;
		cmd.skip_tgt = skip_q;
		cmd.now      = now_q;
		cmd.ttl      = ttl_q;
		cmd.origin   = origin_q;
		cmd.msg_id   = msg_id_q;
		cmd.dest     = dest_q;
		cmd.total    = total_q[6:0];
		cmd.flags    = flags_q;
		cmd.idx      = idx_q[5:0];
		cmd.len      = len_q;
		cmd.pos      = frt_pkg::POS_W'(count_q);
		case (state_q)
			S_EXP_GO, S_EXP_W: cmd.op = frt_pkg::CELL_EXPIRE;
			S_OLD_GO, S_OLD_W: cmd.op = frt_pkg::CELL_OLDEST;
			S_CMP:   cmd.op = gap ? frt_pkg::CELL_SHIFT : frt_pkg::CELL_NOP;
			S_LOOK:  cmd.op = frt_pkg::CELL_LOOKUP;
			S_INS:   cmd.op = frt_pkg::CELL_INSERT;
			S_UPD:   cmd.op = frt_pkg::CELL_UPDATE;
			S_KILL: begin
				cmd.op  = frt_pkg::CELL_KILL_POS;
				cmd.pos = best_pos_q;
			end
			S_KILLT: cmd.op = frt_pkg::CELL_KILL_TGT;
			default: cmd.op = frt_pkg::CELL_NOP;
		endcase
	end

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q       <= 32'd60000;
			max_ent_q   <= 5'd8;
			max_bytes_q <= 18'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				frt_pkg::CFG_TTL:       ttl_q       <= cfg_data;
				frt_pkg::CFG_MAX_ENT:   max_ent_q   <= cfg_data[4:0];
				frt_pkg::CFG_MAX_BYTES: max_bytes_q <= cfg_data[17:0];
				default: begin
				end
			endcase
		end
	end

	// Latch the request on transfer
	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_q     <= opcode;
			origin_q <= origin;
			msg_id_q <= msg_id;
			dest_q   <= dest;
			idx_q    <= frag_index;
			total_q  <= frag_total;
			len_q    <= frag_len;
			flags_q  <= frag_flags;
			now_q    <= now_ms;
		end
	end

	// Sequence one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			held_q  <= '0;
			count_q <= '0;
			skip_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						r_code_q  <= frt_pkg::RES_REJECT;
						r_count_q <= '0;
						r_have_q  <= '0;
						r_dest_q  <= '0;
						r_flags_q <= '0;
						r_len_q   <= '0;
						if (opcode == frt_pkg::OP_ACCEPT) begin
							state_q <= bad_frag ? S_FIN : S_EXP_GO;
						end else if (opcode == frt_pkg::OP_QUERY
							|| opcode == frt_pkg::OP_TAKE) begin
							state_q <= S_LOOK;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_EXP_GO: state_q <= S_EXP_W;
				S_EXP_W: begin
					if (tok[MAX_ENTRIES].active) begin
						held_q  <= held_q - tok[MAX_ENTRIES].acc_bytes;
						count_q <= count_q - CW'(tok[MAX_ENTRIES].acc_cnt);
						ret_q   <= S_LOOK;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (!gap) begin
						state_q <= ret_q;
					end
				end
				S_LOOK: state_q <= S_RD;
				S_RD: begin
					rd_found_q <= c_found;
					rd_count_q <= c_count;
					rd_have_q  <= c_have;
					rd_dest_q  <= c_dest;
					rd_flags_q <= c_flags;
					rd_bytes_q <= c_bytes;
					state_q    <= S_DEC;
				end
				S_DEC: begin
					if (op_q == frt_pkg::OP_ACCEPT) begin
						if (rd_found_q) begin
							if ({1'b0, rd_count_q} != total_q || rd_dest_q != dest_q) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_DUP;
							end
						end else if (7'(count_q) >= lim) begin
							skip_q  <= 1'b0;
							ret_q   <= S_DEC;
							state_q <= S_OLD_GO;
						end else begin
							state_q <= S_INS;
						end
					end else if (!rd_found_q || (op_q == frt_pkg::OP_TAKE
						&& rd_have_q != frt_pkg::full_map(rd_count_q))) begin
						r_code_q <= frt_pkg::RES_NOTFOUND;
						state_q  <= S_FIN;
					end else begin
						r_code_q  <= frt_pkg::RES_FOUND;
						r_count_q <= rd_count_q;
						r_have_q  <= rd_have_q;
						if (op_q == frt_pkg::OP_TAKE) begin
							r_dest_q  <= rd_dest_q;
							r_flags_q <= rd_flags_q;
							r_len_q   <= rd_bytes_q;
							state_q   <= S_KILLT;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_INS: begin
					count_q    <= count_q + CW'(1);
					rd_have_q  <= '0;
					rd_count_q <= total_q[6:0];
					state_q    <= S_DUP;
				end
				S_DUP: begin
					if (rd_have_q[idx_q[5:0]]) begin
						r_code_q <= frt_pkg::RES_DUP;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_BUD;
					end
				end
				S_BUD: begin
					if (over) begin
						if (count_q > CW'(1)) begin
							skip_q  <= 1'b1;
							ret_q   <= S_BUD;
							state_q <= S_OLD_GO;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_UPD;
					end
				end
				S_OLD_GO: state_q <= S_OLD_W;
				S_OLD_W: begin
					if (tok[MAX_ENTRIES].active) begin
						best_pos_q   <= tok[MAX_ENTRIES].pos;
						best_bytes_q <= tok[MAX_ENTRIES].bytes;
						state_q      <= S_KILL;
					end
				end
				S_KILL: begin
					held_q  <= held_q - 18'(best_bytes_q);
					count_q <= count_q - CW'(1);
					state_q <= S_CMP;
				end
				S_KILLT: begin
					held_q  <= held_q - 18'(rd_bytes_q);
					count_q <= count_q - CW'(1);
					ret_q   <= S_FIN;
					state_q <= S_CMP;
				end
				S_UPD: begin
					held_q <= held_q + 18'(len_q);
					if ((rd_have_q | bit_sel) == frt_pkg::full_map(rd_count_q)) begin
						r_code_q <= frt_pkg::RES_COMPLETE;
					end else begin
						r_code_q <= frt_pkg::RES_NEW;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Load the output register when it is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			o_code_q  <= r_code_q;
			o_count_q <= r_count_q;
			o_have_q  <= r_have_q;
			o_dest_q  <= r_dest_q;
			o_flags_q <= r_flags_q;
			o_len_q   <= r_len_q;
		end
	end

	// Row stays packed and counted between requests
	a_packed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !gap)
		else $error("gap in cell row while idle");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(valid_vec) == int'(count_q)))
		else $error("entry count out of step with cell row");

	a_one_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tgt_vec))
		else $error("more than one target cell");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= MAX_ENTRIES)
		else $error("entry count above table depth");

endmodule

`default_nettype wire
